@@ rtl/core/char_lcd_cursor_translator_defines.svh @@
// assertion macros shared by the lcd translator
`ifndef CHAR_LCD_CURSOR_TRANSLATOR_DEFINES_SVH
`define CHAR_LCD_CURSOR_TRANSLATOR_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define CLCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define CLCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/clct_pkg.sv @@
package clct_pkg;

    localparam logic [7:0] CH_BELL   = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;

    localparam logic [2:0] CFG_COLUMNS    = 3'd0;
    localparam logic [2:0] CFG_ROWS       = 3'd1;
    localparam logic [2:0] CFG_ROW_BASE_0 = 3'd2;
    localparam logic [2:0] CFG_ROW_BASE_1 = 3'd3;
    localparam logic [2:0] CFG_ROW_BASE_2 = 3'd4;
    localparam logic [2:0] CFG_ROW_BASE_3 = 3'd5;

    typedef struct packed {
        logic [6:0]       columns;
        logic [2:0]       rows;
        logic [3:0][6:0]  row_base;
    } cfg_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } word_t;

    typedef struct packed {
        logic  two;
        word_t first;
        word_t second;
    } req_t;

    function automatic logic [7:0] set_addr(input logic [6:0] base, input logic [5:0] col);
        logic [6:0] sum;
        sum = base + {1'b0, col};
        return CMD_SET_ADDR | {1'b0, sum};
    endfunction

endpackage

@@ rtl/core/char_lcd_cursor_translator.sv @@
// words of a taken character are registered in the output queue, then offered
// throughput: one character a cycle while each yields one word and the sink
// never stalls, fewer at a row end (two words), set by the single output port
// a four-word output queue lets input run on while the sink stalls
// reset: aresetn synchronous active low, cursor to row 0 column 0, queue empty,
// registers to 16 columns, 2 rows, row bases 0, 64, 16, 80
`include "char_lcd_cursor_translator_defines.svh"

module char_lcd_cursor_translator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_register_select,
    output logic [7:0]  m_write_byte,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    clct_pkg::cfg_t  cfg;
    clct_pkg::req_t  req;
    clct_pkg::word_t out_word;
    logic            take;

    assign cfg_ready = 1'b1;
    assign take      = s_valid && s_ready;

    clct_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clct_cursor u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .character (s_character),
        .cfg       (cfg),
        .req       (req)
    );

    clct_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .req       (req),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign m_register_select = out_word.rs;
    assign m_write_byte      = out_word.data;
    assign m_last            = out_word.last;

    `CLCT_ASSERT_NEXT(a_take_gives_word, take, m_valid, "accepted character produced no word")
    `CLCT_ASSERT_NOW(a_stall_only_when_full, !s_ready, m_valid, "input stalled with queue empty")
    `CLCT_ASSERT_NOW(a_command_form, m_valid && !m_register_select,
        m_write_byte[7] || m_write_byte == clct_pkg::CMD_CLEAR, "malformed command word")

endmodule

@@ rtl/core/clct_cfg.sv @@
module clct_cfg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr,
    input  logic [2:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    output clct_pkg::cfg_t    cfg
);

    clct_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.columns     <= 7'd16;
            cfg_reg.rows        <= 3'd2;
            cfg_reg.row_base[0] <= 7'd0;
            cfg_reg.row_base[1] <= 7'd64;
            cfg_reg.row_base[2] <= 7'd16;
            cfg_reg.row_base[3] <= 7'd80;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                clct_pkg::CFG_COLUMNS:    cfg_reg.columns     <= cfg_data;
                clct_pkg::CFG_ROWS:       cfg_reg.rows        <= cfg_data[2:0];
                clct_pkg::CFG_ROW_BASE_0: cfg_reg.row_base[0] <= cfg_data;
                clct_pkg::CFG_ROW_BASE_1: cfg_reg.row_base[1] <= cfg_data;
                clct_pkg::CFG_ROW_BASE_2: cfg_reg.row_base[2] <= cfg_data;
                clct_pkg::CFG_ROW_BASE_3: cfg_reg.row_base[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/clct_cursor.sv @@
module clct_cursor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        character,
    input  clct_pkg::cfg_t    cfg,
    output clct_pkg::req_t    req
);

    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [5:0] cursor_column_reg, cursor_column_next;
    logic [5:0] last_col;
    logic [1:0] last_row;
    logic       col_at_end, col_past, row_at_end, row_past;
    logic [1:0] row_down;

    // clamp the register values to the usable range
    always_comb begin
        if (cfg.columns == 7'd0)
            last_col = 6'd0;
        else if (cfg.columns >= 7'd64)
            last_col = 6'd63;
        else
            last_col = cfg.columns[5:0] - 6'd1;
        if (cfg.rows == 3'd0)
            last_row = 2'd0;
        else if (cfg.rows >= 3'd4)
            last_row = 2'd3;
        else
            last_row = cfg.rows[1:0] - 2'd1;
    end

    assign col_at_end = cursor_column_reg >= last_col;
    assign col_past   = cursor_column_reg > last_col;
    assign row_at_end = cursor_row_reg >= last_row;
    assign row_past   = cursor_row_reg > last_row;
    assign row_down   = row_at_end ? 2'd0 : cursor_row_reg + 2'd1;

    always_comb begin
        cursor_row_next    = cursor_row_reg;
        cursor_column_next = cursor_column_reg;
        unique case (character)
            clct_pkg::CH_FF: begin
                cursor_row_next    = 2'd0;
                cursor_column_next = 6'd0;
            end
            clct_pkg::CH_CR: cursor_column_next = 6'd0;
            clct_pkg::CH_BS: begin
                if (cursor_column_reg == 6'd0 || col_past)
                    cursor_column_next = last_col;
                else
                    cursor_column_next = cursor_column_reg - 6'd1;
            end
            clct_pkg::CH_TAB:
                cursor_column_next = col_at_end ? 6'd0 : cursor_column_reg + 6'd1;
            clct_pkg::CH_VT: begin
                if (cursor_row_reg == 2'd0 || row_past)
                    cursor_row_next = last_row;
                else
                    cursor_row_next = cursor_row_reg - 2'd1;
            end
            clct_pkg::CH_LF:   cursor_row_next = row_down;
            clct_pkg::CH_BELL: ;
            default: begin
                if (col_at_end) begin
                    cursor_column_next = 6'd0;
                    cursor_row_next    = row_down;
                end else begin
                    cursor_column_next = cursor_column_reg + 6'd1;
                end
            end
        endcase
    end

    // words for this character, addressed from the updated cursor
    always_comb begin
        req.two         = 1'b0;
        req.first.rs    = 1'b0;
        req.first.last  = 1'b1;
        req.first.data  = clct_pkg::set_addr(cfg.row_base[cursor_row_next],
                                             cursor_column_next);
        req.second.rs   = 1'b0;
        req.second.last = 1'b1;
        req.second.data = req.first.data;
        unique case (character) inside
            clct_pkg::CH_FF: req.first.data = clct_pkg::CMD_CLEAR;
            clct_pkg::CH_CR, clct_pkg::CH_BS, clct_pkg::CH_TAB,
            clct_pkg::CH_VT, clct_pkg::CH_LF: ;
            clct_pkg::CH_BELL: begin
                req.first.rs   = 1'b1;
                req.first.data = clct_pkg::CH_STAR;
            end
            default: begin
                req.first.rs   = 1'b1;
                req.first.data = character;
                req.first.last = !col_at_end;
                req.two        = col_at_end;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_row_reg    <= 2'd0;
            cursor_column_reg <= 6'd0;
        end else if (take) begin
            cursor_row_reg    <= cursor_row_next;
            cursor_column_reg <= cursor_column_next;
        end
    end

endmodule

@@ rtl/core/clct_outq.sv @@
module clct_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  clct_pkg::req_t    req,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output clct_pkg::word_t   out_word
);

    localparam int DEPTH = 4;

    clct_pkg::word_t mem [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] push_n;

    assign pop       = out_valid && out_ready;
    assign push_n    = push ? (req.two ? 2'd2 : 2'd1) : 2'd0;
    assign out_valid = count_reg != 3'd0;
    assign out_word  = mem[rd_ptr_reg];
    // space for a two-word character
    assign room      = count_reg <= 3'(DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= req.first;
            if (req.two)
                mem[wr_ptr_reg + 2'd1] <= req.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
